>>> src/bft_pkg.sv
// ----------------------------------------------------------------------------
// Boolean formula tokenizer package
// Token layout, queue sizing and token kind codes shared by the tokenizer.
// ----------------------------------------------------------------------------
package bft_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = 2;

   localparam logic [3:0] KIND_VARIABLE = 4'd0;
   localparam logic [3:0] KIND_OPEN     = 4'd1;
   localparam logic [3:0] KIND_CLOSE    = 4'd2;
   localparam logic [3:0] KIND_NOT      = 4'd3;
   localparam logic [3:0] KIND_AND      = 4'd4;
   localparam logic [3:0] KIND_OR       = 4'd5;
   localparam logic [3:0] KIND_NAND     = 4'd6;
   localparam logic [3:0] KIND_NOR      = 4'd7;
   localparam logic [3:0] KIND_XOR      = 4'd8;
   localparam logic [3:0] KIND_UNKNOWN  = 4'd9;

   typedef logic [QPTR_WIDTH-1:0] qptr_type;
   typedef logic [QPTR_WIDTH:0]   qcount_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        last;
   } token_type;

   // Tokens produced by one byte: count is 0, 1 or 2, tok0 first.
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

endpackage

>>> src/bft_lexer.sv
// ----------------------------------------------------------------------------
// Boolean formula tokenizer lexer
// Registers one input byte, updates the open-word state and produces the
// zero, one or two tokens that the byte completes.
// ----------------------------------------------------------------------------
module bft_lexer #(
   parameter int INDEX_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  logic               room,
   output bft_pkg::push_type  push
);

   localparam int IW = INDEX_WIDTH;

   localparam logic [31:0] KW_OR   = {16'd0, "O", "R"};
   localparam logic [31:0] KW_NOT  = {8'd0, "N", "O", "T"};
   localparam logic [31:0] KW_AND  = {8'd0, "A", "N", "D"};
   localparam logic [31:0] KW_NOR  = {8'd0, "N", "O", "R"};
   localparam logic [31:0] KW_XOR  = {8'd0, "X", "O", "R"};
   localparam logic [31:0] KW_NAND = {"N", "A", "N", "D"};

   function automatic logic [15:0] to16(input logic [IW-1:0] v);
      logic [IW+15:0] w;
      w = {16'd0, v};
      return w[15:0];
   endfunction

   function automatic logic [3:0] word_kind(input logic [IW-1:0] len,
                                            input logic [31:0] kb);
      logic [3:0] k;
      k = bft_pkg::KIND_VARIABLE;
      if (len == IW'(2) && kb == KW_OR) begin
         k = bft_pkg::KIND_OR;
      end else if (len == IW'(3) && kb == KW_NOT) begin
         k = bft_pkg::KIND_NOT;
      end else if (len == IW'(3) && kb == KW_AND) begin
         k = bft_pkg::KIND_AND;
      end else if (len == IW'(3) && kb == KW_NOR) begin
         k = bft_pkg::KIND_NOR;
      end else if (len == IW'(3) && kb == KW_XOR) begin
         k = bft_pkg::KIND_XOR;
      end else if (len == IW'(4) && kb == KW_NAND) begin
         k = bft_pkg::KIND_NAND;
      end
      return k;
   endfunction

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    char_ff;
   logic          last_ff;
   logic          fire;

   logic          in_word_ff, in_word_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [IW-1:0] wstart_ff, wstart_in;
   logic [IW-1:0] wlen_ff, wlen_in;
   logic [31:0]   kbuf_ff, kbuf_in;

   logic          delim, alnum, outside;
   logic [IW-1:0] len_inc;
   logic [31:0]   kb_shift;
   logic          word_emit, out_emit;
   bft_pkg::token_type word_tok, out_tok;

   assign fire        = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         char_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   assign delim = char_ff == " " || char_ff == "(" || char_ff == ")" || char_ff == "!";
   assign alnum = (char_ff >= "0" && char_ff <= "9") || (char_ff >= "A" && char_ff <= "Z")
                  || (char_ff >= "a" && char_ff <= "z");
   assign len_inc  = (&wlen_ff) ? wlen_ff : wlen_ff + IW'(1);
   assign kb_shift = {kbuf_ff[23:0], char_ff};
   // A delimiter closing a word is then treated as a byte outside any word.
   assign outside  = !in_word_ff || delim;

   always_comb begin
      word_emit  = 1'b0;
      out_emit   = 1'b0;
      word_tok   = '0;
      out_tok    = '0;
      in_word_in = in_word_ff;
      wstart_in  = wstart_ff;
      wlen_in    = wlen_ff;
      kbuf_in    = kbuf_ff;

      if (in_word_ff && delim) begin
         word_emit       = 1'b1;
         word_tok.kind   = word_kind(wlen_ff, kbuf_ff);
         word_tok.start  = to16(wstart_ff);
         word_tok.length = to16(wlen_ff);
         in_word_in      = 1'b0;
      end else if (in_word_ff) begin
         wlen_in = len_inc;
         kbuf_in = kb_shift;
         if (last_ff) begin
            word_emit       = 1'b1;
            word_tok.kind   = word_kind(len_inc, kb_shift);
            word_tok.start  = to16(wstart_ff);
            word_tok.length = to16(len_inc);
         end
      end

      if (outside) begin
         out_tok.start  = to16(pos_ff);
         out_tok.length = 16'd1;
         priority if (char_ff == " ") begin
            out_emit = 1'b0;
         end else if (alnum) begin
            in_word_in   = 1'b1;
            wstart_in    = pos_ff;
            wlen_in      = IW'(1);
            kbuf_in      = {24'd0, char_ff};
            out_emit     = last_ff;
            out_tok.kind = bft_pkg::KIND_VARIABLE;
         end else if (char_ff == "(") begin
            out_emit     = 1'b1;
            out_tok.kind = bft_pkg::KIND_OPEN;
         end else if (char_ff == ")") begin
            out_emit     = 1'b1;
            out_tok.kind = bft_pkg::KIND_CLOSE;
         end else if (char_ff == "!") begin
            out_emit     = 1'b1;
            out_tok.kind = bft_pkg::KIND_NOT;
         end else begin
            out_emit     = 1'b1;
            out_tok.kind = bft_pkg::KIND_UNKNOWN;
         end
      end

      word_tok.last = !out_emit;
      out_tok.last  = 1'b1;
      if (last_ff) begin
         in_word_in = 1'b0;
      end
   end

   assign pos_in = last_ff ? '0 : pos_ff + IW'(1);

   always_comb begin
      push.count = 2'd0;
      push.tok0  = word_emit ? word_tok : out_tok;
      push.tok1  = out_tok;
      if (fire) begin
         push.count = {1'b0, word_emit} + {1'b0, out_emit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff <= 1'b0;
         pos_ff     <= '0;
         wstart_ff  <= '0;
         wlen_ff    <= '0;
         kbuf_ff    <= '0;
      end else if (fire) begin
         in_word_ff <= in_word_in;
         pos_ff     <= pos_in;
         wstart_ff  <= wstart_in;
         wlen_ff    <= wlen_in;
         kbuf_ff    <= kbuf_in;
      end
   end

endmodule

>>> src/bft_queue.sv
// ----------------------------------------------------------------------------
// Boolean formula tokenizer output queue
// Four-entry token queue that takes up to two tokens per cycle and hands
// out one token per beat.
// ----------------------------------------------------------------------------
module bft_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  bft_pkg::push_type    push,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bft_pkg::token_type   out_tok,
   output bft_pkg::qcount_type  count
);

   bft_pkg::token_type  q_ff [bft_pkg::QUEUE_DEPTH];
   bft_pkg::qptr_type   wr_ff, wr_in;
   bft_pkg::qptr_type   rd_ff, rd_in;
   bft_pkg::qcount_type count_ff, count_in;
   logic                pop;

   assign out_valid = count_ff != '0;
   assign out_tok   = q_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   // Room for the worst case of two tokens from one byte.
   assign room      = count_ff <= bft_pkg::qcount_type'(bft_pkg::QUEUE_DEPTH - 2);
   assign count     = count_ff;

   assign wr_in    = wr_ff + bft_pkg::qptr_type'(push.count);
   assign rd_in    = rd_ff + bft_pkg::qptr_type'(pop);
   assign count_in = count_ff + bft_pkg::qcount_type'(push.count)
                     - bft_pkg::qcount_type'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push.count != 2'd0) begin
         q_ff[wr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         q_ff[wr_ff + bft_pkg::qptr_type'(1)] <= push.tok1;
      end
   end

endmodule

>>> src/boolean_formula_tokenizer_top.sv
// ----------------------------------------------------------------------------
// Boolean formula tokenizer top level
// Byte stream in, token stream out.
// ----------------------------------------------------------------------------
// One formula byte is taken per beat on req_ and tokens leave one per beat on
// rsp_. A byte can be accepted every cycle. A byte is held in the input
// register and decoded in the following cycle, and its tokens are written to
// the output queue at the end of that cycle if the queue has room, and are
// offered on rsp_ from that queue. A byte that closes a word and is itself a
// delimiter other than a space gives two tokens and so needs two output beats;
// a four-token queue between the decoder and rsp_ absorbs this, and the input
// stalls only while that queue holds more than two tokens. Token start and
// length are truncated to 16 bits, and byte indexes restart at zero after the
// last byte of each formula.
module boolean_formula_tokenizer_top #(
   parameter int INDEX_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [3:0] token_kind, [19:4] token_start,
                                    // [35:20] token_length, [39:36] zero
   output logic        rsp_tlast    // last_of_run
);

   bft_pkg::push_type   push;
   bft_pkg::token_type  tok;
   bft_pkg::qcount_type q_count;
   logic                room;

   bft_lexer #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_lexer (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .room       (room),
      .push       (push)
   );

   bft_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_tok   (tok),
      .count     (q_count)
   );

   assign rsp_tdata = {4'd0, tok.length, tok.start, tok.kind};
   assign rsp_tlast = tok.last;

`ifndef SYNTH
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= bft_pkg::qcount_type'(bft_pkg::QUEUE_DEPTH))
      else $error("token queue overflow");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd3)
      else $error("more than two tokens from one byte");

   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.tok1.last && !push.tok0.last)
      else $error("run marker on the wrong token of a pair");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("tokens pushed without queue room");
`endif

endmodule
